### hdl/csms_pkg.sv
// ----------------------------------------------------------------------------
// csms_pkg: shared types and constants of the core sparing mode selector
// Sizes, packed sample layout, register indexes and the FSM state type.
// ----------------------------------------------------------------------------
package csms_pkg;

  localparam int NUM_CPUS    = 8;
  localparam int NUM_DOMAINS = 2;
  localparam int NUM_MODES   = 4;

  // Fixed field widths of the ports
  localparam int IDX_W    = 3;
  localparam int UTIL_W   = 11;
  localparam int RUN_W    = 8;
  localparam int RTHR_W   = 16;
  localparam int MODE_W   = 3;
  localparam int CFG_IX_W = 3;
  localparam int CFG_W    = 32;

  localparam int CPU_AW     = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
  localparam int CNT_W      = $clog2(NUM_CPUS + 1);
  localparam int UTIL_SUM_W = UTIL_W + CNT_W;
  localparam int RUN_SUM_W  = RUN_W + CNT_W;

  localparam int DOM_MASK_W = NUM_DOMAINS * NUM_CPUS;
  localparam int DOM_UTIL_W = NUM_DOMAINS * UTIL_W;
  localparam int DOM_RUN_W  = NUM_DOMAINS * RTHR_W;
  localparam int MODE_MASK_W = NUM_MODES * NUM_CPUS;

  localparam logic [MODE_W-1:0] NO_MODE = MODE_W'(4);

  typedef logic [NUM_CPUS-1:0] cpu_mask_t;

  typedef struct packed {
    logic [UTIL_W-1:0] util;
    logic [RUN_W-1:0]  run;
    logic              online;
  } sample_t;

  localparam int SAMPLE_W = $bits(sample_t);

  typedef struct packed {
    logic [DOM_MASK_W-1:0] cpu_masks;
    logic [DOM_UTIL_W-1:0] util_thr;
    logic [DOM_RUN_W-1:0]  run_thr;
  } dom_cfg_t;

  typedef struct packed {
    logic [MODE_MASK_W-1:0] cpu_masks;
    logic [NUM_MODES-1:0]   saving;
    logic [2:0]             count;
  } mode_cfg_t;

  typedef struct packed {
    logic      done;
    cpu_mask_t busy;
  } eval_res_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    cpu_mask_t         mask;
  } mode_pick_t;

  typedef enum logic [CFG_IX_W-1:0] {
    CFG_ENABLE      = 3'd0,
    CFG_DOM_MASKS   = 3'd1,
    CFG_DOM_UTIL    = 3'd2,
    CFG_DOM_RUN     = 3'd3,
    CFG_MODE_MASKS  = 3'd4,
    CFG_MODE_SAVING = 3'd5,
    CFG_MODE_COUNT  = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_PICK,
    ST_EMIT
  } state_e;

  function automatic logic [CNT_W-1:0] count_ones(cpu_mask_t v);
    logic [CNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < NUM_CPUS; i++) begin
      n = n + CNT_W'(v[i]);
    end
    return n;
  endfunction

endpackage

### hdl/csms_ram.sv
// ----------------------------------------------------------------------------
// csms_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module csms_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 8,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/csms_eval.sv
// ----------------------------------------------------------------------------
// csms_eval: domain evaluation sweep
// Walks the sample RAM once, sums utilization and run count of the online
// CPUs per domain and flags the CPUs of domains reaching either threshold.
// ----------------------------------------------------------------------------
module csms_eval
  import csms_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  dom_cfg_t          cfg_i,
  output logic [CPU_AW-1:0] rd_addr_o,
  input  sample_t           rd_data_i,
  output eval_res_t         res_o
);

  logic              run_q;
  logic              rd_vld_q;
  logic              last_q;
  logic              done_q;
  logic [CPU_AW-1:0] issue_q;
  logic [CPU_AW-1:0] rd_idx_q;

  logic [UTIL_SUM_W-1:0] util_sum_q [NUM_DOMAINS];
  logic [RUN_SUM_W-1:0]  run_sum_q  [NUM_DOMAINS];
  logic [CNT_W-1:0]      cnt_q      [NUM_DOMAINS];
  cpu_mask_t             online_q;
  cpu_mask_t             busy_q;
  cpu_mask_t             busy_d;

  wire issue_last = (issue_q == CPU_AW'(NUM_CPUS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q    <= 1'b0;
      rd_vld_q <= 1'b0;
      last_q   <= 1'b0;
      done_q   <= 1'b0;
      issue_q  <= '0;
    end else begin
      rd_vld_q <= run_q;
      last_q   <= rd_vld_q && (rd_idx_q == CPU_AW'(NUM_CPUS - 1));
      done_q   <= last_q;
      if (start_i) begin
        run_q   <= 1'b1;
        issue_q <= '0;
      end else if (run_q) begin
        issue_q <= issue_q + CPU_AW'(1);
        if (issue_last) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  // Accumulate one CPU per cycle, if online, into each domain it belongs to
  always_ff @(posedge clk_i) begin
    rd_idx_q <= issue_q;
    if (start_i) begin
      for (int d = 0; d < NUM_DOMAINS; d++) begin
        util_sum_q[d] <= '0;
        run_sum_q[d]  <= '0;
        cnt_q[d]      <= '0;
      end
    end else if (rd_vld_q) begin
      online_q[rd_idx_q] <= rd_data_i.online;
      for (int d = 0; d < NUM_DOMAINS; d++) begin
        if (cfg_i.cpu_masks[d*NUM_CPUS + int'(rd_idx_q)] && rd_data_i.online) begin
          util_sum_q[d] <= util_sum_q[d] + UTIL_SUM_W'(rd_data_i.util);
          run_sum_q[d]  <= run_sum_q[d] + RUN_SUM_W'(rd_data_i.run);
          cnt_q[d]      <= cnt_q[d] + CNT_W'(1);
        end
      end
    end
    if (last_q) begin
      busy_q <= busy_d;
    end
  end

  // floor(sum / n) >= thr is the same as sum >= thr * n
  always_comb begin
    logic [UTIL_SUM_W-1:0] util_lim;
    logic [RTHR_W-1:0]     run_thr;
    cpu_mask_t             cpus;
    busy_d = '0;
    for (int d = 0; d < NUM_DOMAINS; d++) begin
      util_lim = UTIL_SUM_W'(cfg_i.util_thr[d*UTIL_W +: UTIL_W]) * UTIL_SUM_W'(cnt_q[d]);
      run_thr  = cfg_i.run_thr[d*RTHR_W +: RTHR_W];
      cpus     = cfg_i.cpu_masks[d*NUM_CPUS +: NUM_CPUS] & online_q;
      if ((cnt_q[d] != '0) &&
          ((util_sum_q[d] >= util_lim) || (RTHR_W'(run_sum_q[d]) >= run_thr))) begin
        busy_d = busy_d | cpus;
      end
    end
  end

  assign rd_addr_o  = issue_q;
  assign res_o.done = done_q;
  assign res_o.busy = busy_q;

endmodule

### hdl/csms_mode.sv
// ----------------------------------------------------------------------------
// csms_mode: mode picker
// Takes the highest mode in use that is not a saving mode too small for the
// busy CPUs; falls back to mode 0.
// ----------------------------------------------------------------------------
module csms_mode
  import csms_pkg::*;
(
  input  mode_cfg_t  cfg_i,
  input  cpu_mask_t  busy_i,
  output mode_pick_t pick_o
);

  logic [CNT_W-1:0] busy_n;

  assign busy_n = count_ones(busy_i);

  always_comb begin
    cpu_mask_t m_mask;
    logic      in_use;
    logic      skip;
    pick_o.mode = '0;
    pick_o.mask = cfg_i.cpu_masks[NUM_CPUS-1:0];
    // ascending walk: the last hit is the highest usable mode
    for (int m = 0; m < NUM_MODES; m++) begin
      m_mask = cfg_i.cpu_masks[m*NUM_CPUS +: NUM_CPUS];
      in_use = (m == 0) || (3'(m) < cfg_i.count);
      skip   = cfg_i.saving[m] && (count_ones(m_mask) <= busy_n);
      if (in_use && !skip) begin
        pick_o.mode = MODE_W'(m);
        pick_o.mask = m_mask;
      end
    end
  end

endmodule

### hdl/core_sparing_mode_selector_top.sv
// ----------------------------------------------------------------------------
// core_sparing_mode_selector_top: per-CPU load table and sparing mode choice
// Stores per-CPU samples in a RAM and, on the last sample of a round,
// judges each domain busy or not and picks the CPU mode that results.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one CPU sample per item.
//   A sample without last_sample is written into the sample RAM and
//   produces no result.
//   A sample with last_sample produces one result item on the output
//   channel (out_valid_o / out_stall_i). With the governor enabled the
//   evaluation sweeps the sample RAM one CPU per cycle over its single read
//   port, and when the busy mask changed a mode is chosen before the result
//   is loaded into the output register. With the governor off the result
//   is loaded without an evaluation.
//   Input is stalled during an evaluation. The result sits in an output
//   register; plain samples are still taken while it waits, and a further
//   last sample waits only at its final step until the register is free.
//   Configuration is written through cfg_we_i / cfg_index_i / cfg_wdata_i
//   while the block is idle. Toggling enable selects mode 0 at once.
//   Reset marks every table entry unwritten (read as zero, CPU offline),
//   clears the busy mask, and sets the allowed mask to all ones, no mode.
// ----------------------------------------------------------------------------
module core_sparing_mode_selector_top
  import csms_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // input channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [IDX_W-1:0]    cpu_index_i,
  input  logic [UTIL_W-1:0]   cpu_util_i,
  input  logic [RUN_W-1:0]    run_count_i,
  input  logic                online_i,
  input  logic                last_sample_i,
  // output channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [NUM_CPUS-1:0] allowed_mask_o,
  output logic [NUM_CPUS-1:0] sparing_mask_o,
  output logic [NUM_CPUS-1:0] busy_mask_o,
  output logic [MODE_W-1:0]   mode_index_o,
  output logic                status_changed_o,
  output logic                mode_changed_o,
  // configuration
  input  logic                cfg_we_i,
  input  logic [CFG_IX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]    cfg_wdata_i
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic      enable_q;
  dom_cfg_t  dom_cfg_q;
  mode_cfg_t mode_cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q             <= 1'b1;
      dom_cfg_q.cpu_masks  <= '0;
      dom_cfg_q.util_thr   <= '1;
      dom_cfg_q.run_thr    <= '1;
      mode_cfg_q.cpu_masks <= '1;
      mode_cfg_q.saving    <= '0;
      mode_cfg_q.count     <= 3'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_ENABLE:      enable_q             <= cfg_wdata_i[0];
        CFG_DOM_MASKS:   dom_cfg_q.cpu_masks  <= cfg_wdata_i[DOM_MASK_W-1:0];
        CFG_DOM_UTIL:    dom_cfg_q.util_thr   <= cfg_wdata_i[DOM_UTIL_W-1:0];
        CFG_DOM_RUN:     dom_cfg_q.run_thr    <= cfg_wdata_i[DOM_RUN_W-1:0];
        CFG_MODE_MASKS:  mode_cfg_q.cpu_masks <= cfg_wdata_i[MODE_MASK_W-1:0];
        CFG_MODE_SAVING: mode_cfg_q.saving    <= cfg_wdata_i[NUM_MODES-1:0];
        CFG_MODE_COUNT:  mode_cfg_q.count     <= cfg_wdata_i[2:0];
        default: ;
      endcase
    end
  end

  wire enable_flip = cfg_we_i && (cfg_index_i == CFG_ENABLE) && (cfg_wdata_i[0] != enable_q);

  // --------------------------------------------------------------------------
  // Sample RAM, evaluation sweep and mode picker
  // --------------------------------------------------------------------------
  state_e      state_q, state_d;
  logic        in_accept;
  logic        ram_we;
  logic        eval_start;
  logic [CPU_AW-1:0] rd_addr;
  logic [CPU_AW-1:0] rd_addr_q;
  cpu_mask_t   written_q;
  sample_t     wr_sample;
  sample_t     rd_sample_raw;
  sample_t     rd_sample;
  eval_res_t   eval_res;
  mode_pick_t  pick;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  // drop samples for CPUs beyond the table
  assign ram_we     = in_accept && (int'(cpu_index_i) < NUM_CPUS);

  assign wr_sample.util   = cpu_util_i;
  assign wr_sample.run    = run_count_i;
  assign wr_sample.online = online_i;

  csms_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (NUM_CPUS),
    .ADDR_W(CPU_AW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(cpu_index_i[CPU_AW-1:0]),
    .wdata_i(wr_sample),
    .raddr_i(rd_addr),
    .rdata_o(rd_sample_raw)
  );

  // Track written entries so an unwritten one reads as an idle, offline CPU
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
      rd_addr_q <= '0;
    end else begin
      rd_addr_q <= rd_addr;
      if (ram_we) begin
        written_q[cpu_index_i[CPU_AW-1:0]] <= 1'b1;
      end
    end
  end

  assign rd_sample = written_q[rd_addr_q] ? rd_sample_raw : '0;

  csms_eval u_eval (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (eval_start),
    .cfg_i    (dom_cfg_q),
    .rd_addr_o(rd_addr),
    .rd_data_i(rd_sample),
    .res_o    (eval_res)
  );

  // --------------------------------------------------------------------------
  // Governor state and sequencer
  // --------------------------------------------------------------------------
  cpu_mask_t         busy_q, busy_d;
  cpu_mask_t         allowed_q, allowed_d;
  logic [MODE_W-1:0] cur_mode_q, cur_mode_d;
  logic              stat_chg_q, stat_chg_d;
  logic              mode_chg_q, mode_chg_d;
  logic              out_load;
  logic              out_valid_q;

  csms_mode u_mode (
    .cfg_i (mode_cfg_q),
    .busy_i(busy_q),
    .pick_o(pick)
  );

  always_comb begin
    state_d    = state_q;
    busy_d     = busy_q;
    allowed_d  = allowed_q;
    cur_mode_d = cur_mode_q;
    stat_chg_d = stat_chg_q;
    mode_chg_d = mode_chg_q;
    eval_start = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept && last_sample_i) begin
          stat_chg_d = 1'b0;
          mode_chg_d = 1'b0;
          if (enable_q) begin
            eval_start = 1'b1;
            state_d    = ST_SWEEP;
          end else begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_SWEEP: begin
        if (eval_res.done) begin
          if (eval_res.busy != busy_q) begin
            busy_d     = eval_res.busy;
            stat_chg_d = 1'b1;
            state_d    = ST_PICK;
          end else begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_PICK: begin
        // busy_q now holds the new mask; adopt the picked mode if it moved
        if (pick.mode != cur_mode_q) begin
          cur_mode_d = pick.mode;
          allowed_d  = pick.mask;
          mode_chg_d = 1'b1;
        end
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        // hold until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    // enable toggle forces mode 0; toggle only while idle, which the block does not enforce
    if (enable_flip) begin
      cur_mode_d = '0;
      allowed_d  = mode_cfg_q.cpu_masks[NUM_CPUS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      busy_q     <= '0;
      allowed_q  <= '1;
      cur_mode_q <= NO_MODE;
      stat_chg_q <= 1'b0;
      mode_chg_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      busy_q     <= busy_d;
      allowed_q  <= allowed_d;
      cur_mode_q <= cur_mode_d;
      stat_chg_q <= stat_chg_d;
      mode_chg_q <= mode_chg_d;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      allowed_mask_o   <= allowed_q;
      sparing_mask_o   <= enable_q ? ~allowed_q : '0;
      busy_mask_o      <= busy_q;
      mode_index_o     <= cur_mode_q;
      status_changed_o <= stat_chg_q;
      mode_changed_o   <= mode_chg_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### hdl/csms_checker.sv
// ----------------------------------------------------------------------------
// csms_checker: port-level checks of the core sparing mode selector
// Watches the top level's ports only; attached by bind.
// ----------------------------------------------------------------------------
module csms_checker
  import csms_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic [IDX_W-1:0]    cpu_index_i,
  input logic [UTIL_W-1:0]   cpu_util_i,
  input logic [RUN_W-1:0]    run_count_i,
  input logic                online_i,
  input logic                last_sample_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic [NUM_CPUS-1:0] allowed_mask_o,
  input logic [NUM_CPUS-1:0] sparing_mask_o,
  input logic [NUM_CPUS-1:0] busy_mask_o,
  input logic [MODE_W-1:0]   mode_index_o,
  input logic                status_changed_o,
  input logic                mode_changed_o,
  input logic                cfg_we_i,
  input logic [CFG_IX_W-1:0] cfg_index_i,
  input logic [CFG_W-1:0]    cfg_wdata_i
);

  // a stalled item stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(allowed_mask_o))
    else $error("output item dropped while stalled");

  // a mode is adopted only when the busy mask moved
  a_mode_needs_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && mode_changed_o |-> status_changed_o)
    else $error("mode changed without a busy change");

  // an adopted mode is a real mode
  a_mode_real: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && mode_changed_o |-> mode_index_o != NO_MODE)
    else $error("adopted mode is the no-mode code");

  // sparing is either off or the complement of allowed
  a_sparing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (sparing_mask_o == '0) || (sparing_mask_o == ~allowed_mask_o))
    else $error("sparing mask inconsistent with allowed mask");

endmodule

bind core_sparing_mode_selector_top csms_checker u_csms_checker (.*);
